/* rtl/swps_pkg.sv */
// Package with payload types, state codes and constants of the position smoother.
package swps_pkg;

	localparam int unsigned ALPHA_W = 17;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd32768;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [31:0] sample_time;
	} swps_in_t;

	typedef struct packed {
		logic signed [23:0] mean_x;
		logic signed [23:0] mean_y;
		logic signed [23:0] wmean_x;
		logic signed [23:0] wmean_y;
		logic signed [23:0] ema_x;
		logic signed [23:0] ema_y;
		logic [24:0] rms_spread;
		logic [31:0] newest_time;
	} swps_out_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV_MX,
		ST_DIV_MY,
		ST_DIV_WX,
		ST_DIV_WY,
		ST_EMA,
		ST_SQ,
		ST_DIV_SQ,
		ST_SQRT,
		ST_OUT
	} swps_state_t;

endpackage

/* rtl/sliding_window_position_smoother_top.sv */
// Top level of the sliding-window position smoother: window memory, sequencer and shared units.
// One word in gives one word out. Each of the three window walks steps through read, sum,
// x product and y product for each sample it visits. The shared restoring divider runs five
// times (load, then one quotient bit per cycle). D is the divider width, 56 bits for a window
// of 16. The bit-pair square root follows, and ST_OUT loads the output register. While an item
// is in work in_stall is high. The result waits in an output register, and the next item can
// be accepted from the cycle after the result is taken.
module sliding_window_position_smoother_top import swps_pkg::*; #(
	parameter int unsigned WINDOW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  swps_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output swps_out_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ALPHA_W-1:0] cfg_data
);

	localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CW = $clog2(WINDOW + 1);
	// Sum of weights n(n+1)/2 fits in 2*CW bits; weighted sums need 24 + 2*CW bits.
	localparam int unsigned WSW = 24 + 2 * CW + 1;
	// Squared sum: each term below 2^50, times WINDOW.
	localparam int unsigned SQW = 50 + CW + 1;
	localparam int unsigned DW = (WSW > SQW) ? WSW : SQW;
	localparam int unsigned DCW = $clog2(DW + 1);
	localparam int unsigned RW = 32;

	// Window memory, read data registered for the walks; the EMA seed reads the oldest entry directly.
	logic signed [23:0] mem_x [WINDOW];
	logic signed [23:0] mem_y [WINDOW];
	logic [AW-1:0] rd_addr;
	logic signed [23:0] rd_x_q, rd_y_q;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW:0] wr_sum, rd_sum;

	logic [ALPHA_W-1:0] alpha_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] fill_q;
	logic [31:0] time_q;

	swps_state_t state_q, state_d;
	logic [CW:0] idx_q;
	logic rd_pend_q;

	logic signed [WSW-1:0] sx_q, sy_q, wx_q, wy_q;
	logic [2*CW-1:0] tw_q;
	logic signed [23:0] mx_q, my_q, ex_q, ey_q, wmx_q, wmy_q;
	logic [SQW-1:0] sq_q;
	logic [24:0] rms_q;
	swps_out_t out_q;
	logic out_valid_q;
	logic first_q;

	// Shared divider: magnitude restoring division, one bit per cycle.
	logic [DW-1:0] dv_num_q, dv_rem_q;
	logic [DW-1:0] dv_den_q;
	logic dv_neg_q;
	logic [DCW-1:0] dv_cnt_q;
	logic dv_busy_q;
	logic [DW:0] dv_trial;
	logic [DW:0] dv_shift;

	// Square root state.
	logic [2*RW-1:0] sr_val_q;
	logic [RW:0] sr_res_q;
	logic [RW+1:0] sr_rem_q;
	logic [5:0] sr_cnt_q;
	logic [RW+1:0] sr_trial;

	// Shared multiplier for weighted sum, EMA and squares.
	logic signed [24:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [50:0] mul_p;
	logic signed [50:0] mul_q;
	logic mul_v_q;

	logic [ALPHA_W-1:0] alpha_eff;
	logic signed [24:0] dx, dy;
	logic [CW:0] n_ext;

	assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign n_ext = {1'b0, fill_q};

	// Input acceptance and window write address.
	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	assign wr_en = in_acc;
	assign wr_sum = {1'b0, oldest_q} + (AW+1)'(fill_q);
	always_comb begin
		if (fill_q < CW'(WINDOW)) begin
			if (wr_sum >= (AW+1)'(WINDOW)) wr_addr = AW'(wr_sum - (AW+1)'(WINDOW));
			else wr_addr = AW'(wr_sum);
		end else begin
			wr_addr = oldest_q;
		end
	end

	// Read address walks window from oldest.
	assign rd_sum = {1'b0, oldest_q} + (AW+1)'(idx_q);
	assign rd_addr = (rd_sum >= (AW+1)'(WINDOW)) ? AW'(rd_sum - (AW+1)'(WINDOW)) : AW'(rd_sum);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= in_data.pos_x;
			mem_y[wr_addr] <= in_data.pos_y;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	// Config register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alpha_q <= cfg_data;
		end
	end

	// Next state.
	logic last_idx;
	assign last_idx = (idx_q == n_ext - 1'b1);
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_SUM;
			ST_SUM: if (mul_v_q && last_idx && !rd_pend_q) state_d = ST_DIV_MX;
			ST_DIV_MX: if (dv_busy_q && dv_cnt_q == '0) state_d = ST_DIV_MY;
			ST_DIV_MY: if (dv_busy_q && dv_cnt_q == '0) state_d = ST_DIV_WX;
			ST_DIV_WX: if (dv_busy_q && dv_cnt_q == '0) state_d = ST_DIV_WY;
			ST_DIV_WY: if (dv_busy_q && dv_cnt_q == '0) state_d = ST_EMA;
			// A single sample only needs the seed, taken in the first cycle.
			ST_EMA: if (n_ext == (CW+1)'(1) || (mul_v_q && last_idx && !rd_pend_q))
				state_d = ST_SQ;
			ST_SQ: if (mul_v_q && last_idx && !rd_pend_q) state_d = ST_DIV_SQ;
			ST_DIV_SQ: if (dv_busy_q && dv_cnt_q == '0) state_d = ST_SQRT;
			ST_SQRT: if (sr_cnt_q == '0) state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Multiplier operand selection: weighted terms, EMA blend, squared distances.
	// Within a walk each index runs through the phases read (rd_pend), sum, x product and y product.
	logic mul_ph_q;
	assign dx = 25'(rd_x_q) - 25'(mx_q);
	assign dy = 25'(rd_y_q) - 25'(my_q);
	always_comb begin
		mul_a = 25'(rd_x_q);
		mul_b = 26'(idx_q) + 26'sd1;
		unique case (state_q)
			ST_SUM: begin
				mul_a = mul_ph_q ? 25'(rd_y_q) : 25'(rd_x_q);
				mul_b = 26'($signed({1'b0, idx_q})) + 26'sd1;
			end
			ST_EMA: begin
				mul_a = mul_ph_q ? (25'(rd_y_q) - 25'(ey_q)) : (25'(rd_x_q) - 25'(ex_q));
				mul_b = 26'($signed({1'b0, alpha_eff}));
			end
			ST_SQ: begin
				mul_a = mul_ph_q ? dy : dx;
				mul_b = mul_ph_q ? 26'(dy) : 26'(dx);
			end
			default: begin
				mul_a = 25'(rd_x_q);
				mul_b = 26'sd1;
			end
		endcase
	end
	assign mul_p = 51'(mul_a) * 51'(mul_b);

	// EMA step: trunc((a*v+(65536-a)*s)/65536), formed as s*65536 + a*(v-s);
	// truncation toward zero applies on the whole sum.
	// The x product is in mul_q while mul_ph is high, the y product in the following cycle.
	logic signed [50:0] ema_num;
	logic signed [50:0] ema_s;
	logic signed [50:0] ema_q_res;
	assign ema_s = mul_ph_q ? 51'(ex_q) : 51'(ey_q);
	assign ema_num = (ema_s <<< 16) + mul_q;
	assign ema_q_res = (ema_num < 0) ? -((-ema_num) >>> 16) : (ema_num >>> 16);

	// Walk control and accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			mul_ph_q <= 1'b0;
			mul_v_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE || state_d != state_q) begin
				idx_q <= (state_d == ST_EMA) ? (CW+1)'(1) : '0;
				rd_pend_q <= 1'b1;
				mul_ph_q <= 1'b0;
				mul_v_q <= 1'b0;
				first_q <= 1'b1;
			end else if (state_q == ST_SUM || state_q == ST_EMA || state_q == ST_SQ) begin
				first_q <= 1'b0;
				if (rd_pend_q) begin
					rd_pend_q <= 1'b0;
					mul_ph_q <= 1'b0;
					mul_v_q <= 1'b0;
				end else if (!mul_ph_q && !mul_v_q) begin
					mul_ph_q <= 1'b1;
				end else if (mul_ph_q) begin
					mul_ph_q <= 1'b0;
					mul_v_q <= 1'b1;
				end else if (!last_idx) begin
					idx_q <= idx_q + 1'b1;
					rd_pend_q <= 1'b1;
					mul_v_q <= 1'b0;
				end
			end
		end
	end

	// Product register and accumulators.
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (in_acc) begin
			time_q <= in_data.sample_time;
			sx_q <= '0;
			sy_q <= '0;
			wx_q <= '0;
			wy_q <= '0;
			sq_q <= '0;
		end
		unique case (state_q)
			ST_SUM: begin
				if (!rd_pend_q && !mul_ph_q && !mul_v_q) begin
					sx_q <= sx_q + WSW'(rd_x_q);
					sy_q <= sy_q + WSW'(rd_y_q);
				end else if (!rd_pend_q && mul_ph_q) begin
					wx_q <= wx_q + WSW'(mul_q);
				end else if (!rd_pend_q && mul_v_q) begin
					wy_q <= wy_q + WSW'(mul_q);
				end
			end
			ST_EMA: begin
				if (idx_q == (CW+1)'(1) && rd_pend_q && first_q) begin
					ex_q <= mem_x[oldest_q];
					ey_q <= mem_y[oldest_q];
				end else if (!rd_pend_q && mul_ph_q) begin
					ex_q <= 24'(ema_q_res);
				end else if (!rd_pend_q && mul_v_q) begin
					ey_q <= 24'(ema_q_res);
				end
			end
			ST_SQ: begin
				if (!rd_pend_q && mul_ph_q) begin
					sq_q <= sq_q + SQW'(unsigned'(mul_q));
				end else if (!rd_pend_q && mul_v_q) begin
					sq_q <= sq_q + SQW'(unsigned'(mul_q));
				end
			end
			default: ;
		endcase
	end

	// Divider operand selection and iteration.
	logic signed [DW-1:0] dv_src;
	logic [DW-1:0] dv_dsr;
	always_comb begin
		dv_src = DW'(sx_q);
		dv_dsr = DW'(n_ext);
		unique case (state_q)
			ST_DIV_MX: begin dv_src = DW'(sx_q); dv_dsr = DW'(n_ext); end
			ST_DIV_MY: begin dv_src = DW'(sy_q); dv_dsr = DW'(n_ext); end
			ST_DIV_WX: begin dv_src = DW'(wx_q); dv_dsr = DW'(tw_q); end
			ST_DIV_WY: begin dv_src = DW'(wy_q); dv_dsr = DW'(tw_q); end
			ST_DIV_SQ: begin dv_src = DW'(sq_q); dv_dsr = DW'(n_ext); end
			default: begin dv_src = DW'(sx_q); dv_dsr = DW'(n_ext); end
		endcase
	end
	assign dv_shift = {dv_rem_q, dv_num_q[DW-1]};
	assign dv_trial = dv_shift - {1'b0, dv_den_q};

	logic [DW-1:0] dv_quot;
	assign dv_quot = {dv_num_q[DW-2:0], ~dv_trial[DW]};
	logic [DW-1:0] dv_signed;
	assign dv_signed = dv_neg_q ? (~dv_quot + 1'b1) : dv_quot;

	logic is_div;
	assign is_div = (state_q == ST_DIV_MX) || (state_q == ST_DIV_MY) ||
		(state_q == ST_DIV_WX) || (state_q == ST_DIV_WY) || (state_q == ST_DIV_SQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q <= '0;
		end else if (is_div && !dv_busy_q) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q <= DCW'(DW - 1);
		end else if (dv_busy_q) begin
			if (dv_cnt_q == '0) dv_busy_q <= 1'b0;
			else dv_cnt_q <= dv_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tw_q <= (2*CW)'(((32'(fill_q < CW'(WINDOW) ? fill_q + 1'b1 : fill_q)) *
				(32'(fill_q < CW'(WINDOW) ? fill_q + 1'b1 : fill_q) + 32'd1)) >> 1);
		end
		if (is_div && !dv_busy_q) begin
			dv_neg_q <= (state_q != ST_DIV_SQ) && dv_src[DW-1];
			dv_num_q <= ((state_q != ST_DIV_SQ) && dv_src[DW-1]) ? (~dv_src + 1'b1) : dv_src;
			dv_den_q <= dv_dsr;
			dv_rem_q <= '0;
		end else if (dv_busy_q) begin
			dv_num_q <= dv_quot;
			dv_rem_q <= dv_trial[DW] ? dv_shift[DW-1:0] : dv_trial[DW-1:0];
			if (dv_cnt_q == '0) begin
				unique case (state_q)
					ST_DIV_MX: mx_q <= 24'(dv_signed);
					ST_DIV_MY: my_q <= 24'(dv_signed);
					ST_DIV_WX: wmx_q <= 24'(dv_signed);
					ST_DIV_WY: wmy_q <= 24'(dv_signed);
					default: ;
				endcase
			end
		end
	end

	// Square root: two bits of the radicand per cycle. The radicand is the quotient that
	// the divider holds in the last cycle of the mean-square division.
	assign sr_trial = {sr_rem_q[RW-1:0], sr_val_q[2*RW-1 -: 2]} - {sr_res_q[RW-1:0], 2'b01};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_cnt_q <= '0;
		end else if (state_q == ST_DIV_SQ) begin
			sr_cnt_q <= 6'(RW);
		end else if (state_q == ST_SQRT && sr_cnt_q != '0) begin
			sr_cnt_q <= sr_cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_SQ) begin
			sr_val_q <= (2*RW)'(dv_quot);
			sr_res_q <= '0;
			sr_rem_q <= '0;
		end else if (state_q == ST_SQRT && sr_cnt_q != '0) begin
			sr_val_q <= sr_val_q << 2;
			if (!sr_trial[RW+1]) begin
				sr_rem_q <= sr_trial;
				sr_res_q <= {sr_res_q[RW-1:0], 1'b1};
			end else begin
				sr_rem_q <= {sr_rem_q[RW-1:0], sr_val_q[2*RW-1 -: 2]};
				sr_res_q <= {sr_res_q[RW-1:0], 1'b0};
			end
		end else if (state_q == ST_SQRT) begin
			rms_q <= 25'(sr_res_q);
		end
	end

	// Window pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q <= '0;
		end else if (in_acc) begin
			if (fill_q < CW'(WINDOW)) fill_q <= fill_q + 1'b1;
			else oldest_q <= (oldest_q == AW'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			out_q.mean_x <= mx_q;
			out_q.mean_y <= my_q;
			out_q.wmean_x <= wmx_q;
			out_q.wmean_y <= wmy_q;
			out_q.ema_x <= ex_q;
			out_q.ema_y <= ey_q;
			out_q.rms_spread <= rms_q;
			out_q.newest_time <= time_q;
		end
	end

endmodule

/* rtl/swps_checker.sv */
// Port checker for the position smoother, bound to the top level.
module swps_checker import swps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input swps_out_t out_data,
	input logic cfg_valid,
	input logic cfg_ready
);

	// A held result word does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// No new item is taken while a result waits.
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	// Config is only taken when the block is idle.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !in_stall)
		else $error("config ready while busy");

	// An accepted item makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("block not busy after accept");

endmodule

bind sliding_window_position_smoother_top swps_checker u_swps_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
